@@ rtl/srss_pkg.sv @@
`default_nettype none

package srss_pkg;

    // Field and register widths
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned RANGE_W  = 17;
    localparam int unsigned SUBSET_W = 7;
    localparam int unsigned STATUS_W = 2;

    // Register reset values
    localparam logic [RANGE_W-1:0]  RANGE_SIZE_RESET  = 17'd65536;
    localparam logic [SUBSET_W-1:0] SUBSET_SIZE_RESET = 7'd64;

    // Register indexes on the APB port
    localparam logic REG_RANGE_SIZE  = 1'b0;
    localparam logic REG_SUBSET_SIZE = 1'b1;

    // Command kinds
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_DRAW    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd2;

    // Draw sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_WRITE_R,
        ST_WRITE_I
    } t_state;

endpackage

`default_nettype wire

@@ rtl/sparse_random_subset_sampler_core.sv @@
// Channel   | Signals                                   | Beat taken when
// ----------+-------------------------------------------+-----------------------------
// command   | start, busy, i_kind, i_rand_index         | start && !busy at clock edge
// result    | o_valid, o_picked, o_last, o_status       | o_valid, one cycle, no stall
// config    | psel, penable, pwrite, paddr, pwdata,     | psel && penable && pwrite
//           | prdata, pready                            | (pready tied high)
//
// A restart, or a draw rejected up front, leaves busy low; a rejected draw's result
// appears in the following cycle. An accepted draw holds busy through one sweep of
// the swap table through its single read port with one key comparator pair, a decide
// state and up to two writes through the single write port; with the defaults a draw
// starts with at most 126 entries. Its result appears in the cycle busy drops.
// Reset clears the fill count and step counter; table contents need no clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module sparse_random_subset_sampler_core
    import srss_pkg::*;
#(
    parameter int unsigned MAX_K         = 64,
    parameter int unsigned TABLE_ENTRIES = 128,
    parameter int unsigned INDEX_BITS    = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command
    input  wire logic                start,
    output      logic                busy,
    input  wire logic                i_kind,
    input  wire logic [INDEX_W-1:0]  i_rand_index,
    // result
    output      logic                o_valid,
    output      logic [INDEX_W-1:0]  o_picked,
    output      logic                o_last,
    output      logic [STATUS_W-1:0] o_status,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output      logic [31:0]         prdata,
    output      logic                pready
);

    localparam int unsigned KEY_W  = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
    localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned STEP_W = $clog2(MAX_K + 1);
    localparam int unsigned KW     = (STEP_W > SUBSET_W) ? STEP_W : SUBSET_W;
    localparam int unsigned N_CAP  = (INDEX_BITS >= RANGE_W) ? ((1 << RANGE_W) - 1)
                                                            : (1 << INDEX_BITS);

    // Configuration registers
    logic [RANGE_W-1:0]  r_range_size;
    logic [SUBSET_W-1:0] r_subset_size;

    // Sequencer and table state
    t_state              r_state, n_state;
    logic [USED_W-1:0]   r_used;
    logic [USED_W-1:0]   r_addr;
    logic [STEP_W-1:0]   r_step;
    logic [KEY_W-1:0]    r_rkey;
    logic                r_same;
    logic                r_found_i, r_found_r;
    logic [SLOT_W-1:0]   r_slot_i, r_slot_r;
    logic [KEY_W-1:0]    r_val_i, r_val_r;
    logic                r_rd_valid;
    logic [SLOT_W-1:0]   r_rd_slot;

    // Swap table: key in the upper half, value in the lower half
    logic [2*KEY_W-1:0]  r_mem [TABLE_ENTRIES];
    logic [2*KEY_W-1:0]  r_mem_q;

    // Result register
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_picked;
    logic                r_out_last;
    logic [STATUS_W-1:0] r_out_status;

    // Combinational controls
    logic                accept, cfg_wr;
    logic [RANGE_W-1:0]  n_eff;
    logic [KW-1:0]       k_eff;
    logic                subset_done, out_of_range;
    logic [KEY_W-1:0]    step_key;
    logic                hit_i, hit_r;
    logic                rd_en, mem_we;
    logic [SLOT_W-1:0]   mem_wa;
    logic [2*KEY_W-1:0]  mem_wd;
    logic [USED_W:0]     need, used_after;
    logic                table_full;
    logic [USED_W-1:0]   used_p1;
    logic [KEY_W-1:0]    vi, vr;
    logic [STEP_W-1:0]   step_p1;
    logic                finish;

    assign accept   = start && !busy;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign busy     = (r_state != ST_IDLE);
    assign step_key = KEY_W'(r_step);
    assign step_p1  = r_step + STEP_W'(1);
    assign used_p1  = r_used + USED_W'(1);

    // Saturate n and k to what the datapath holds
    assign n_eff = (r_range_size > RANGE_W'(N_CAP)) ? RANGE_W'(N_CAP) : r_range_size;
    assign k_eff = (KW'(r_subset_size) > KW'(MAX_K)) ? KW'(MAX_K) : KW'(r_subset_size);

    // Up-front draw checks
    assign subset_done  = (KW'(r_step) >= k_eff);
    assign out_of_range = (i_rand_index < INDEX_W'(r_step)) ||
                          ({1'b0, i_rand_index} >= n_eff);

    // Key compare on the swept entry
    assign hit_i = r_rd_valid && (r_mem_q[2*KEY_W-1:KEY_W] == step_key);
    assign hit_r = r_rd_valid && (r_mem_q[2*KEY_W-1:KEY_W] == r_rkey);

    // Entries a swap would add
    assign need       = (USED_W+1)'(!r_found_i) + (USED_W+1)'(!r_same && !r_found_r);
    assign used_after = {1'b0, r_used} + need;
    assign table_full = (used_after > (USED_W+1)'(TABLE_ENTRIES));

    // Values now at positions i and r
    assign vi = r_found_i ? r_val_i : step_key;
    assign vr = r_found_r ? r_val_r : r_rkey;

    // Config readback
    always_comb begin
        case (paddr[2])
            REG_RANGE_SIZE:  prdata = 32'(r_range_size);
            REG_SUBSET_SIZE: prdata = 32'(r_subset_size);
            default:         prdata = '0;
        endcase
    end

    // Next state and controls
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = r_slot_r;
        mem_wd  = {r_rkey, r_val_i};
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_kind == KIND_DRAW) && !subset_done && !out_of_range) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                rd_en = (r_addr < r_used);
                if (!rd_en) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = table_full ? ST_IDLE : ST_WRITE_R;
            end
            ST_WRITE_R: begin
                mem_we = 1'b1;
                if (r_same) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WRITE_I;
                end
            end
            ST_WRITE_I: begin
                mem_we  = 1'b1;
                mem_wa  = r_slot_i;
                mem_wd  = {step_key, r_val_r};
                finish  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_size  <= RANGE_SIZE_RESET;
            r_subset_size <= SUBSET_SIZE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_RANGE_SIZE:  r_range_size  <= pwdata[RANGE_W-1:0];
                REG_SUBSET_SIZE: r_subset_size <= pwdata[SUBSET_W-1:0];
                default:         r_range_size  <= r_range_size;
            endcase
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_addr[SLOT_W-1:0]];
        end
    end

    // Fill count, step counter and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_step     <= '0;
            r_addr     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= rd_en;
            if (rd_en) begin
                r_addr <= r_addr + USED_W'(1);
            end
            if (accept && (i_kind == KIND_RESTART)) begin
                r_used <= '0;
                r_step <= '0;
            end
            if (accept) begin
                r_addr <= '0;
            end
            if ((r_state == ST_CHECK) && !table_full) begin
                r_used <= used_after[USED_W-1:0];
            end
            if (finish) begin
                r_step <= step_p1;
            end
        end
    end

    // Search results, then write targets
    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_addr[SLOT_W-1:0];
        if (accept) begin
            r_rkey    <= KEY_W'(i_rand_index);
            r_same    <= (i_rand_index == INDEX_W'(r_step));
            r_found_i <= 1'b0;
            r_found_r <= 1'b0;
        end else if (r_state == ST_CHECK) begin
            // point slots at the write targets, allocating new entries in order
            r_slot_r <= r_found_r ? r_slot_r : r_used[SLOT_W-1:0];
            r_slot_i <= r_found_i ? r_slot_i
                      : (r_found_r ? r_used[SLOT_W-1:0] : used_p1[SLOT_W-1:0]);
            r_val_i  <= vi;
            r_val_r  <= vr;
        end else begin
            if (hit_i) begin
                r_found_i <= 1'b1;
                r_slot_i  <= r_rd_slot;
                r_val_i   <= r_mem_q[KEY_W-1:0];
            end
            if (hit_r) begin
                r_found_r <= 1'b1;
                r_slot_r  <= r_rd_slot;
                r_val_r   <= r_mem_q[KEY_W-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (accept && (i_kind == KIND_DRAW) && (subset_done || out_of_range))
                        || ((r_state == ST_CHECK) && table_full) || finish;
        end
        if (accept) begin
            r_out_picked <= '0;
            r_out_last   <= 1'b0;
            r_out_status <= subset_done ? STATUS_DONE : STATUS_RANGE;
        end else if (r_state == ST_CHECK) begin
            r_out_picked <= '0;
            r_out_last   <= 1'b0;
            r_out_status <= STATUS_RANGE;
        end else if (finish) begin
            r_out_picked <= INDEX_W'(r_val_r);
            r_out_last   <= (KW'(step_p1) == k_eff);
            r_out_status <= STATUS_OK;
        end else begin
            r_out_picked <= '0;
            r_out_last   <= 1'b0;
            r_out_status <= STATUS_OK;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_picked = r_out_picked;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

    // Results only follow a taken command or sequencer activity
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a command");

    // Fill count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_ENTRIES))
        else $error("table fill count overflow");

    // Step counter stays within MAX_K
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_step) <= KW'(MAX_K))
        else $error("draw step overflow");

    // Rejected draws carry no element and no last mark
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |-> ((o_picked == '0) && !o_last))
        else $error("rejected draw carries data");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import srss_pkg::*;

    localparam int unsigned SLOTS         = 128;
    localparam int unsigned K_CAP         = 64;
    localparam int unsigned N_CAP         = 65536;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [INDEX_W-1:0]  picked;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_pick;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_kind;
    logic [INDEX_W-1:0]  i_rand_index;
    logic                o_valid;
    logic [INDEX_W-1:0]  o_picked;
    logic                o_last;
    logic [STATUS_W-1:0] o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow of the sparse shuffle table and the draw position
    logic [INDEX_W-1:0]  moved_pos [SLOTS];
    logic [INDEX_W-1:0]  moved_val [SLOTS];
    logic                moved_live [SLOTS];
    int unsigned         moved_count;
    int unsigned         pick_count;
    logic [RANGE_W-1:0]  cfg_n;
    logic [SUBSET_W-1:0] cfg_k;

    t_pick       expected_picks[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    bit          gaps_on = 1'b1;

    sparse_random_subset_sampler_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_rand_index (i_rand_index),
        .o_valid      (o_valid),
        .o_picked     (o_picked),
        .o_last       (o_last),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock, 20 ns period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Shuffle predictor
    // ------------------------------------------------------------------
    function automatic void clear_shuffle();
        foreach (moved_live[s])
            moved_live[s] = 1'b0;
        moved_count = 0;
        pick_count  = 0;
    endfunction

    function automatic int unsigned effective_n();
        return (cfg_n > N_CAP) ? N_CAP : cfg_n;
    endfunction

    function automatic int unsigned effective_k();
        return (cfg_k > K_CAP) ? K_CAP : cfg_k;
    endfunction

    function automatic int lookup_moved(input int unsigned pos);
        for (int unsigned s = 0; s < moved_count && s < SLOTS; s++) begin
            if (moved_live[s] && moved_pos[s] == pos)
                return s;
        end
        return -1;
    endfunction

    // Untouched positions hold their own index
    function automatic int unsigned value_at(input int unsigned pos);
        int s;
        s = lookup_moved(pos);
        return (s < 0) ? pos : moved_val[s];
    endfunction

    function automatic void store_at(input int unsigned pos, input int unsigned val);
        int s;
        s = lookup_moved(pos);
        if (s < 0) begin
            if (moved_count >= SLOTS)
                return;
            s = moved_count;
            moved_count++;
            moved_pos[s]  = pos[INDEX_W-1:0];
            moved_live[s] = 1'b1;
        end
        moved_val[s] = val[INDEX_W-1:0];
    endfunction

    // Apply one accepted command and, for a draw, queue the result it reports
    task automatic shuffle_command(input logic kind, input logic [INDEX_W-1:0] idx);
        t_pick       res;
        int unsigned n_eff;
        int unsigned k_eff;
        int unsigned step;
        int unsigned need;
        int unsigned vi;
        int unsigned vr;
        if (kind == KIND_RESTART) begin
            clear_shuffle();
            return;
        end
        n_eff = effective_n();
        k_eff = effective_k();
        step  = pick_count;
        res   = '0;
        if (step >= k_eff) begin
            res.status = STATUS_DONE;
        end else if (idx < step || idx >= n_eff) begin
            res.status = STATUS_RANGE;
        end else begin
            need = (lookup_moved(step) < 0) ? 1 : 0;
            if (idx != step && lookup_moved(idx) < 0)
                need++;
            if (moved_count + need > SLOTS) begin
                res.status = STATUS_RANGE;
            end else begin
                vi = value_at(step);
                vr = value_at(idx);
                store_at(idx, vi);
                store_at(step, vr);
                pick_count = step + 1;
                res.picked = vr[INDEX_W-1:0];
                res.last   = (pick_count == k_eff);
                res.status = STATUS_OK;
            end
        end
        expected_picks.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one beat at a falling edge, hold it until taken; start stays high on return
    task automatic send_item(input logic kind, input logic [INDEX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        = 1'b1;
        i_kind       = kind;
        i_rand_index = idx;
        do
            @(posedge i_clk);
        while (busy);
        shuffle_command(kind, idx);
        @(negedge i_clk);
    endtask

    // Drop start and wait for every queued draw to come back
    task automatic hold_until_drained();
        start = 1'b0;
        while (expected_picks.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    // Index outside [step, n-1], or any index where no such index exists
    function automatic logic [INDEX_W-1:0] stray_index();
        int unsigned n_eff;
        bit          low_ok;
        bit          high_ok;
        n_eff   = effective_n();
        low_ok  = (pick_count > 0);
        high_ok = (n_eff < N_CAP);
        if (low_ok && (!high_ok || $urandom_range(0, 1) == 0))
            return INDEX_W'($urandom_range(0, pick_count - 1));
        if (high_ok)
            return INDEX_W'($urandom_range(n_eff, N_CAP - 1));
        return INDEX_W'($urandom_range(0, N_CAP - 1));
    endfunction

    function automatic logic [INDEX_W-1:0] fitting_index();
        int unsigned n_eff;
        n_eff = effective_n();
        if (n_eff <= pick_count)
            return stray_index();
        return INDEX_W'(pick_count + $urandom_range(0, n_eff - 1 - pick_count));
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [31:0] want,
                             input string name);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata !== want)
            report_mismatch(name, prdata, want);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Reprogram n and k once the block has gone quiet
    task automatic set_config(input int unsigned n, input int unsigned k);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg({REG_RANGE_SIZE, 2'b00}, n);
        cfg_n = n[RANGE_W-1:0];
        write_reg({REG_SUBSET_SIZE, 2'b00}, k);
        cfg_k = k[SUBSET_W-1:0];
        check_reg({REG_RANGE_SIZE, 2'b00}, 32'(cfg_n), "range_size readback");
        check_reg({REG_SUBSET_SIZE, 2'b00}, 32'(cfg_k), "subset_size readback");
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver never stalls, so take every strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_valid) begin
            if (expected_picks.size() == 0) begin
                report_mismatch("unexpected result, picked", 32'(o_picked), 32'd0);
            end else begin
                want = expected_picks.pop_front();
                if (o_picked !== want.picked)
                    report_mismatch("picked", 32'(o_picked), 32'(want.picked));
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sparse_random_subset_sampler_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        check_reg({REG_RANGE_SIZE, 2'b00}, 32'(RANGE_SIZE_RESET), "range_size reset");
        check_reg({REG_SUBSET_SIZE, 2'b00}, 32'(SUBSET_SIZE_RESET), "subset_size reset");
    endtask

    task automatic test_directed_draws();
        gaps_on = 1'b0;
        // Index equal to step, top of the range, below step, swapped slot read back
        send_item(KIND_DRAW, 16'd0);
        send_item(KIND_DRAW, 16'hFFFF);
        send_item(KIND_DRAW, 16'd1);
        send_item(KIND_DRAW, 16'd2);
        send_item(KIND_DRAW, 16'hFFFF);
        // Restart must forget the swaps
        send_item(KIND_RESTART, 16'hFFFF);
        send_item(KIND_DRAW, 16'hFFFF);
        // Smallest range and subset: index at n, last draw, complete before range
        set_config(1, 1);
        send_item(KIND_DRAW, 16'd1);
        send_item(KIND_DRAW, 16'd0);
        send_item(KIND_DRAW, 16'd0);
        send_item(KIND_RESTART, 16'd0);
        // Change k in the middle of a subset
        set_config(5, 3);
        send_item(KIND_DRAW, 16'd4);
        send_item(KIND_DRAW, 16'd4);
        set_config(5, 2);
        send_item(KIND_DRAW, 16'd4);
        set_config(5, 4);
        send_item(KIND_DRAW, 16'd3);
        send_item(KIND_DRAW, 16'd3);
        send_item(KIND_RESTART, 16'h5555);
        set_config(N_CAP, K_CAP);
        gaps_on = 1'b1;
    endtask

    // Mostly complete subsets with random content, plus stray indexes,
    // draws past the end and early restarts
    task automatic run_phase(input int unsigned n, input int unsigned k,
                             input int unsigned count, input bit with_gaps);
        int unsigned sent;
        int unsigned roll;
        set_config(n, k);
        gaps_on = with_gaps;
        send_item(KIND_RESTART, INDEX_W'($urandom_range(0, N_CAP - 1)));
        sent = 1;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll == 0)
                hold_until_drained();
            if (pick_count >= effective_k()) begin
                if (roll < 75)
                    send_item(KIND_RESTART, INDEX_W'($urandom_range(0, N_CAP - 1)));
                else
                    send_item(KIND_DRAW, INDEX_W'($urandom_range(0, N_CAP - 1)));
            end else if (roll < 3) begin
                send_item(KIND_RESTART, INDEX_W'($urandom_range(0, N_CAP - 1)));
            end else if (roll < 15) begin
                send_item(KIND_DRAW, stray_index());
            end else begin
                send_item(KIND_DRAW, fitting_index());
            end
            sent++;
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_subsets();
        run_phase(N_CAP, K_CAP, 200, 1'b1);
        run_phase(1, 1, 60, 1'b1);
        run_phase(K_CAP, K_CAP, 150, 1'b1);
        run_phase(40, K_CAP, 100, 1'b1);
        run_phase(200, K_CAP, 120, 1'b0);
        run_phase(1000, 3, 80, 1'b1);
        run_phase(N_CAP - 1, K_CAP, 100, 1'b1);
        repeat (3)
            run_phase($urandom_range(1, N_CAP), $urandom_range(1, K_CAP), 60,
                      1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_RESTART;
        i_rand_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_n        = RANGE_SIZE_RESET;
        cfg_k        = SUBSET_SIZE_RESET;
        clear_shuffle();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_defaults();
        test_directed_draws();
        test_random_subsets();

        // Drain, then let any trailing restart settle
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("sparse_random_subset_sampler_core verification clean");
        end else begin
            $display("sparse_random_subset_sampler_core verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/srss_pkg.sv
rtl/sparse_random_subset_sampler_core.sv
dv/tb_top.sv
